// ----- rtl/lpmb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmb_pkg
// Shared types and constants for the layer priority mux and blend pipeline.
// ----------------------------------------------------------------------------
package lpmb_pkg;

	localparam int unsigned COLOR_W   = 15;
	localparam int unsigned LAYER_W   = 16;
	localparam int unsigned CHAN_W    = 5;
	localparam int unsigned WEIGHT_W  = 5;
	localparam int unsigned PROD_W    = 10;
	localparam int unsigned NUM_BG    = 4;
	localparam int unsigned NUM_LAYER = 5;
	localparam int unsigned NUM_PRIO  = 4;
	localparam int unsigned IN_W      = 96;
	localparam int unsigned OUT_W     = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 15;
	localparam int unsigned ID_W      = 3;

	localparam logic [ID_W-1:0] ID_OBJ      = 3'd4;
	localparam logic [ID_W-1:0] ID_BACKDROP = 3'd5;

	localparam logic [CHAN_W-1:0]   CHAN_MAX    = 5'd31;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 5'd16;
	localparam logic [OUT_W-1:0]    PIXEL_WHITE = 32'hFFFF_FFFF;
	localparam logic [7:0]          ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISPLAY_ENABLES = 3'd0,
		CFG_BG_PRIORITIES   = 3'd1,
		CFG_BLEND_CONTROL   = 3'd2,
		CFG_ALPHA_FIRST     = 3'd3,
		CFG_ALPHA_SECOND    = 3'd4,
		CFG_BRIGHTNESS      = 3'd5,
		CFG_BACKDROP        = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_NONE     = 2'd0,
		MODE_ALPHA    = 2'd1,
		MODE_BRIGHTEN = 2'd2,
		MODE_DARKEN   = 2'd3
	} blend_mode_t;

	typedef enum logic [1:0] {
		OP_PASS   = 2'd0,
		OP_ALPHA  = 2'd1,
		OP_BRIGHT = 2'd2,
		OP_DARK   = 2'd3
	} blend_op_t;

	function automatic logic [WEIGHT_W-1:0] clamp16(input logic [WEIGHT_W-1:0] v);
		return (v > WEIGHT_MAX) ? WEIGHT_MAX : v;
	endfunction

endpackage

// ----- rtl/layer_priority_mux_and_blend_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_priority_mux_and_blend_top
// Per-pixel compositor: picks the top two visible layers and blends them.
// ----------------------------------------------------------------------------
// channel   | handshake                     | payload
// s_axis    | s_axis_tvalid / s_axis_tready | s_axis_tdata[88:0] layer pixels, mask
// m_axis    | m_axis_tvalid / m_axis_tready | m_axis_tdata[31:0] R8 G8 B8 A8
// cfg       | cfg_valid / cfg_ready         | cfg_index[2:0], cfg_data[14:0]
//
// one pixel per clock unless the output stalls; each pixel passes the stage 1, 2 and 3 registers
// stage 1 layer pick, stage 2 blend decision and channel multiplies, stage 3 sum, clip, expand
// arst_n clears stage valids and all registers to zero
// a stalled output holds each stage that has data; empty stages still fill
// cfg_ready is always high; write registers only while the pipe is empty
// ----------------------------------------------------------------------------
module layer_priority_mux_and_blend_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// bg0_color, bg1_color, bg2_color, bg3_color, obj_color (16 each),
	// obj_priority (2), obj_semi (1), window_mask (6), zero fill
	input  logic [lpmb_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// pixel_rgba (32)
	output logic [lpmb_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lpmb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpmb_pkg::CFG_DAT_W-1:0] cfg_data
);
	import lpmb_pkg::*;

	localparam int unsigned NUM_CAND = NUM_PRIO * NUM_LAYER;

	// configuration registers
	logic [5:0]          disp_en_q;
	logic [7:0]          bg_prio_q;
	logic [13:0]         blend_ctl_q;
	logic [WEIGHT_W-1:0] alpha_a_q;
	logic [WEIGHT_W-1:0] alpha_b_q;
	logic [WEIGHT_W-1:0] bright_q;
	logic [COLOR_W-1:0]  backdrop_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_en_q   <= '0;
			bg_prio_q   <= '0;
			blend_ctl_q <= '0;
			alpha_a_q   <= '0;
			alpha_b_q   <= '0;
			bright_q    <= '0;
			backdrop_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DISPLAY_ENABLES: disp_en_q   <= cfg_data[5:0];
				CFG_BG_PRIORITIES:   bg_prio_q   <= cfg_data[7:0];
				CFG_BLEND_CONTROL:   blend_ctl_q <= cfg_data[13:0];
				CFG_ALPHA_FIRST:     alpha_a_q   <= cfg_data[WEIGHT_W-1:0];
				CFG_ALPHA_SECOND:    alpha_b_q   <= cfg_data[WEIGHT_W-1:0];
				CFG_BRIGHTNESS:      bright_q    <= cfg_data[WEIGHT_W-1:0];
				CFG_BACKDROP:        backdrop_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3           = !v_s3 || m_axis_tready;
	assign en2           = !v_s2 || en3;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;

	// ---------------- stage 1: layer pick ----------------
	logic [LAYER_W-1:0]  lyr_raw   [NUM_LAYER];
	logic [COLOR_W-1:0]  lyr_col   [NUM_LAYER];
	logic [ID_W-1:0]     lyr_id    [NUM_LAYER];
	logic [NUM_LAYER-1:0] lyr_vis;
	logic [1:0]          lyr_prio  [NUM_LAYER];
	logic [1:0]          in_oprio;
	logic                in_semi;
	logic [5:0]          in_mask;
	logic [NUM_CAND-1:0] cand, hit0, rest, hit1;
	logic [NUM_LAYER-1:0] sel0, sel1;
	logic [ID_W-1:0]     pick_id0, pick_id1;
	logic [COLOR_W-1:0]  pick_col0, pick_col1;

	assign in_oprio = s_axis_tdata[81:80];
	assign in_semi  = s_axis_tdata[82];
	assign in_mask  = s_axis_tdata[88:83];

	always_comb begin
		// layer slot 0 is the sprite, slots 1 to 4 are backgrounds 0 to 3
		lyr_raw[0]  = s_axis_tdata[64 +: LAYER_W];
		lyr_id[0]   = ID_OBJ;
		lyr_prio[0] = in_oprio;
		lyr_vis[0]  = disp_en_q[4] && in_mask[4] && !lyr_raw[0][LAYER_W-1];
		for (int i = 0; i < NUM_BG; i++) begin
			lyr_raw[i+1]  = s_axis_tdata[i*LAYER_W +: LAYER_W];
			lyr_id[i+1]   = ID_W'(i);
			lyr_prio[i+1] = bg_prio_q[2*i +: 2];
			lyr_vis[i+1]  = disp_en_q[i] && in_mask[i] && !lyr_raw[i+1][LAYER_W-1];
		end
		for (int j = 0; j < NUM_LAYER; j++) begin
			lyr_col[j] = lyr_raw[j][COLOR_W-1:0];
		end
		for (int p = 0; p < NUM_PRIO; p++) begin
			for (int j = 0; j < NUM_LAYER; j++) begin
				cand[p*NUM_LAYER + j] = lyr_vis[j] && (lyr_prio[j] == 2'(p));
			end
		end
		// lowest set bit gives the top layer, the next one the second layer
		hit0 = cand & (~cand + NUM_CAND'(1));
		rest = cand & ~hit0;
		hit1 = rest & (~rest + NUM_CAND'(1));
		for (int j = 0; j < NUM_LAYER; j++) begin
			sel0[j] = 1'b0;
			sel1[j] = 1'b0;
			for (int p = 0; p < NUM_PRIO; p++) begin
				sel0[j] = sel0[j] | hit0[p*NUM_LAYER + j];
				sel1[j] = sel1[j] | hit1[p*NUM_LAYER + j];
			end
		end
		pick_id0  = (|sel0) ? '0 : ID_BACKDROP;
		pick_id1  = (|sel1) ? '0 : ID_BACKDROP;
		pick_col0 = (|sel0) ? '0 : backdrop_q;
		pick_col1 = (|sel1) ? '0 : backdrop_q;
		for (int j = 0; j < NUM_LAYER; j++) begin
			if (sel0[j]) begin
				pick_id0  = pick_id0 | lyr_id[j];
				pick_col0 = pick_col0 | lyr_col[j];
			end
			if (sel1[j]) begin
				pick_id1  = pick_id1 | lyr_id[j];
				pick_col1 = pick_col1 | lyr_col[j];
			end
		end
	end

	logic [ID_W-1:0]    id0_s1, id1_s1;
	logic [COLOR_W-1:0] col0_s1, col1_s1;
	logic               semi_s1, fx_s1, blank_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			id0_s1   <= '0;
			id1_s1   <= '0;
			col0_s1  <= '0;
			col1_s1  <= '0;
			semi_s1  <= 1'b0;
			fx_s1    <= 1'b0;
			blank_s1 <= 1'b0;
		end else if (en1) begin
			v_s1     <= s_axis_tvalid;
			id0_s1   <= pick_id0;
			id1_s1   <= pick_id1;
			col0_s1  <= pick_col0;
			col1_s1  <= pick_col1;
			semi_s1  <= in_semi;
			fx_s1    <= in_mask[5];
			blank_s1 <= disp_en_q[5];
		end
	end

	// ---------------- stage 2: blend decision and multiplies ----------------
	logic          first_ok, second_ok;
	logic [5:0]    first_tgt, second_tgt;
	blend_mode_t   mode;
	blend_op_t     op;
	logic [WEIGHT_W-1:0] wa, wb, wy;
	logic [CHAN_W-1:0]   ca [3];
	logic [CHAN_W-1:0]   cb [3];
	logic [PROD_W-1:0]   pa [3];
	logic [PROD_W-1:0]   pb [3];

	assign first_tgt  = blend_ctl_q[5:0];
	assign second_tgt = blend_ctl_q[13:8];
	assign first_ok   = first_tgt[id0_s1];
	assign second_ok  = second_tgt[id1_s1];
	assign mode      = blend_mode_t'(blend_ctl_q[7:6]);
	assign wa        = clamp16(alpha_a_q);
	assign wb        = clamp16(alpha_b_q);
	assign wy        = clamp16(bright_q);

	always_comb begin
		// a semi-transparent sprite on top overrides the mode when the layer below is a second target
		priority if (!fx_s1)                                     op = OP_PASS;
		else if (id0_s1 == ID_OBJ && semi_s1 && second_ok)       op = OP_ALPHA;
		else if (mode == MODE_ALPHA && first_ok && second_ok)    op = OP_ALPHA;
		else if (mode == MODE_BRIGHTEN && first_ok)              op = OP_BRIGHT;
		else if (mode == MODE_DARKEN && first_ok)                op = OP_DARK;
		else                                                     op = OP_PASS;
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ca[k] = col0_s1[k*CHAN_W +: CHAN_W];
			cb[k] = col1_s1[k*CHAN_W +: CHAN_W];
			unique case (op)
				OP_ALPHA: begin
					pa[k] = PROD_W'(ca[k]) * PROD_W'(wa);
					pb[k] = PROD_W'(cb[k]) * PROD_W'(wb);
				end
				OP_BRIGHT: begin
					pa[k] = PROD_W'(CHAN_MAX - ca[k]) * PROD_W'(wy);
					pb[k] = '0;
				end
				OP_DARK: begin
					pa[k] = PROD_W'(ca[k]) * PROD_W'(wy);
					pb[k] = '0;
				end
				default: begin
					pa[k] = '0;
					pb[k] = '0;
				end
			endcase
		end
	end

	blend_op_t          op_s2;
	logic [COLOR_W-1:0] col0_s2;
	logic               blank_s2;
	logic [PROD_W-1:0]  pa_s2 [3];
	logic [PROD_W-1:0]  pb_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			op_s2    <= OP_PASS;
			col0_s2  <= '0;
			blank_s2 <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= '0;
				pb_s2[k] <= '0;
			end
		end else if (en2) begin
			v_s2     <= v_s1;
			op_s2    <= op;
			col0_s2  <= col0_s1;
			blank_s2 <= blank_s1;
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= pa[k];
				pb_s2[k] <= pb[k];
			end
		end
	end

	// ---------------- stage 3: sum, clip, expand ----------------
	logic [PROD_W:0]    psum [3];
	logic [CHAN_W-1:0]  cv   [3];
	logic [CHAN_W-1:0]  res  [3];
	logic [7:0]         c8   [3];
	logic [OUT_W-1:0]   pixel;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cv[k]   = col0_s2[k*CHAN_W +: CHAN_W];
			psum[k] = (PROD_W+1)'(pa_s2[k]) + (PROD_W+1)'(pb_s2[k]);
			unique case (op_s2)
				OP_ALPHA:  res[k] = (psum[k][PROD_W:4] > (PROD_W-3)'(CHAN_MAX)) ?
					CHAN_MAX : psum[k][CHAN_W+3:4];
				OP_BRIGHT: res[k] = cv[k] + pa_s2[k][CHAN_W+3:4];
				OP_DARK:   res[k] = cv[k] - pa_s2[k][CHAN_W+3:4];
				default:   res[k] = cv[k];
			endcase
			c8[k] = {res[k], res[k][CHAN_W-1:2]};
		end
		pixel = blank_s2 ? PIXEL_WHITE : {c8[0], c8[1], c8[2], ALPHA_OPAQUE};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3         <= 1'b0;
			m_axis_tdata <= '0;
		end else if (en3) begin
			v_s3         <= v_s2;
			m_axis_tdata <= pixel;
		end
	end

	assign m_axis_tvalid = v_s3;

	// ---------------- checks ----------------
	a_blank_white: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en3 && blank_s2) |=> (m_axis_tdata == PIXEL_WHITE))
		else $error("forced blank did not give white");

	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] == ALPHA_OPAQUE))
		else $error("output alpha byte not opaque");

	a_layers_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && id0_s1 != ID_BACKDROP) |-> (id0_s1 != id1_s1))
		else $error("same layer picked twice");

	a_backdrop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && id0_s1 == ID_BACKDROP) |-> (id1_s1 == ID_BACKDROP))
		else $error("second layer visible with no top layer");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en2) |=> (v_s2 && $stable(col0_s2) && $stable(op_s2)))
		else $error("stage 2 changed while stalled");

endmodule

// ----- tb/layer_priority_mux_and_blend_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_priority_mux_and_blend_top_tb
// Self-checking bench for the per-pixel layer compositor. A short table of
// hand-picked pixels under fixed register settings comes first, then random
// pixels under a run of register settings. Each pixel is scored against a
// typed result or the local model, with random backpressure on both streams.
// ----------------------------------------------------------------------------
module layer_priority_mux_and_blend_top_tb;
	import lpmb_pkg::*;

	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          PHASES       = 12;
	localparam int          PHASE_PIXELS = 160;
	localparam logic [15:0] CLEAR_PX     = 16'hFFFF;
	localparam logic [31:0] RGBA_BLACK   = {24'h0, ALPHA_OPAQUE};

	// register file as the compositor sees it
	typedef struct packed {
		logic [5:0]  enables;
		logic [7:0]  prios;
		logic [13:0] blend;
		logic [4:0]  wa;
		logic [4:0]  wb;
		logic [4:0]  wy;
		logic [14:0] backdrop;
	} settings_t;

	// same layout as s_axis_tdata, lowest field last
	typedef struct packed {
		logic [6:0]  fill;
		logic [5:0]  mask;
		logic        semi;
		logic [1:0]  prio;
		logic [15:0] obj;
		logic [15:0] bg3;
		logic [15:0] bg2;
		logic [15:0] bg1;
		logic [15:0] bg0;
	} pixel_req_t;

	typedef struct packed {
		settings_t   st;
		pixel_req_t  px;
		logic        has_typed;
		logic [31:0] typed_val;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_data;

	settings_t   live_regs = '0;
	settings_t   drv_regs  = '0;
	logic [31:0] rgba_due_q[$];
	logic [32:0] typed_rgba_q[$];
	stim_row_t   directed_rows[$];
	int          pixels_in      = 0;
	int          pixels_out     = 0;
	int          typed_count    = 0;
	int          settings_count = 0;
	int          fail_count     = 0;
	int          cycle_count    = 0;
	bit          steady_flow    = 1'b0;

	layer_priority_mux_and_blend_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// compositor model
	// ------------------------------------------------------------------------
	function automatic int sixteenths(input logic [4:0] w);
		return (w > 5'd16) ? 16 : int'(w);
	endfunction

	function automatic logic [14:0] mix_layers(input logic [14:0] a, input logic [14:0] b,
			input int wa, input int wb);
		logic [14:0] out;
		int          v;
		int          k;
		out = '0;
		for (k = 0; k < 3; k++) begin
			v = (int'(a[5*k +: 5]) * wa + int'(b[5*k +: 5]) * wb) >> 4;
			if (v > 31)
				v = 31;
			out[5*k +: 5] = v[4:0];
		end
		return out;
	endfunction

	function automatic logic [14:0] lift_toward_white(input logic [14:0] c, input int w);
		logic [14:0] out;
		int          v;
		int          k;
		out = '0;
		for (k = 0; k < 3; k++) begin
			v = int'(c[5*k +: 5]);
			v = v + (((31 - v) * w) >> 4);
			out[5*k +: 5] = v[4:0];
		end
		return out;
	endfunction

	function automatic logic [14:0] sink_toward_black(input logic [14:0] c, input int w);
		logic [14:0] out;
		int          v;
		int          k;
		out = '0;
		for (k = 0; k < 3; k++) begin
			v = int'(c[5*k +: 5]);
			v = v - ((v * w) >> 4);
			out[5*k +: 5] = v[4:0];
		end
		return out;
	endfunction

	function automatic logic [31:0] to_rgba(input logic [14:0] c);
		return {c[4:0], c[4:2], c[9:5], c[9:7], c[14:10], c[14:12], ALPHA_OPAQUE};
	endfunction

	function automatic logic [31:0] composite_pixel(input settings_t st, input pixel_req_t px);
		logic [3:0][15:0] bg_col;
		logic [1:0][2:0]  pick_id;
		logic [1:0][14:0] pick_col;
		logic [14:0]      res;
		logic [5:0]       tgt_a;
		logic [5:0]       tgt_b;
		bit               obj_on;
		bit               first_ok;
		bit               second_ok;
		int               wa;
		int               wb;
		int               p;
		int               b;
		int               n;
		if (st.enables[5])
			return PIXEL_WHITE;
		bg_col = {px.bg3, px.bg2, px.bg1, px.bg0};
		obj_on = st.enables[4] && px.mask[4] && !px.obj[15];
		n = 0;
		// sprite wins ties against backgrounds, lower background wins among bgs
		for (p = 0; p < NUM_PRIO; p++) begin
			if (n < 2 && obj_on && px.prio == p) begin
				pick_id[n]  = ID_OBJ;
				pick_col[n] = px.obj[14:0];
				n++;
			end
			for (b = 0; b < NUM_BG; b++) begin
				if (n < 2 && st.enables[b] && px.mask[b] && !bg_col[b][15] &&
						st.prios[2*b +: 2] == p) begin
					pick_id[n]  = 3'(b);
					pick_col[n] = bg_col[b][14:0];
					n++;
				end
			end
		end
		while (n < 2) begin
			pick_id[n]  = ID_BACKDROP;
			pick_col[n] = st.backdrop;
			n++;
		end
		res = pick_col[0];
		if (px.mask[5]) begin
			tgt_a     = st.blend[5:0];
			tgt_b     = st.blend[13:8];
			first_ok  = tgt_a[pick_id[0]];
			second_ok = tgt_b[pick_id[1]];
			wa = sixteenths(st.wa);
			wb = sixteenths(st.wb);
			// a semi-transparent sprite on top blends regardless of the mode when the layer below is a second target
			if (pick_id[0] == ID_OBJ && px.semi && second_ok)
				res = mix_layers(pick_col[0], pick_col[1], wa, wb);
			else begin
				case (st.blend[7:6])
					MODE_ALPHA: begin
						if (first_ok && second_ok)
							res = mix_layers(pick_col[0], pick_col[1], wa, wb);
					end
					MODE_BRIGHTEN: begin
						if (first_ok)
							res = lift_toward_white(pick_col[0], sixteenths(st.wy));
					end
					MODE_DARKEN: begin
						if (first_ok)
							res = sink_toward_black(pick_col[0], sixteenths(st.wy));
					end
					default: ;
				endcase
			end
		end
		return to_rgba(res);
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic settings_t mk_settings(input logic [5:0] en, input logic [7:0] pr,
			input logic [13:0] bc, input logic [4:0] a1, input logic [4:0] a2,
			input logic [4:0] y, input logic [14:0] bd);
		settings_t st;
		st.enables  = en;
		st.prios    = pr;
		st.blend    = bc;
		st.wa       = a1;
		st.wb       = a2;
		st.wy       = y;
		st.backdrop = bd;
		return st;
	endfunction

	function automatic pixel_req_t mk_pixel(input logic [15:0] c0, input logic [15:0] c1,
			input logic [15:0] c2, input logic [15:0] c3, input logic [15:0] co,
			input logic [1:0] pr, input logic sm, input logic [5:0] wm);
		pixel_req_t px;
		px      = '0;
		px.bg0  = c0;
		px.bg1  = c1;
		px.bg2  = c2;
		px.bg3  = c3;
		px.obj  = co;
		px.prio = pr;
		px.semi = sm;
		px.mask = wm;
		return px;
	endfunction

	function automatic logic [15:0] rand_layer();
		logic [15:0] v;
		int          r;
		v = 16'($urandom);
		r = $urandom_range(99);
		if (r < 25)
			v = CLEAR_PX;
		else if (r < 35)
			v[15] = 1'b1;
		else
			v[15] = 1'b0;
		return v;
	endfunction

	function automatic pixel_req_t rand_pixel();
		pixel_req_t px;
		px      = '0;
		px.bg0  = rand_layer();
		px.bg1  = rand_layer();
		px.bg2  = rand_layer();
		px.bg3  = rand_layer();
		px.obj  = rand_layer();
		px.prio = 2'($urandom_range(3));
		px.semi = 1'($urandom_range(1));
		px.mask = 6'($urandom);
		if ($urandom_range(99) < 60)
			px.mask[5] = 1'b1;
		return px;
	endfunction

	function automatic settings_t rand_settings();
		settings_t st;
		st = mk_settings(6'($urandom), 8'($urandom), 14'($urandom), 5'($urandom),
			5'($urandom), 5'($urandom), 15'($urandom));
		st.enables[5] = ($urandom_range(7) == 0);
		if ($urandom_range(1))
			st.enables[4] = 1'b1;
		if ($urandom_range(99) < 40) begin
			st.wa = 5'($urandom_range(16));
			st.wb = 5'($urandom_range(16));
			st.wy = 5'($urandom_range(16));
		end
		return st;
	endfunction

	task automatic add_row(input settings_t st, input pixel_req_t px, input logic has_typed,
			input logic [31:0] typed_val);
		stim_row_t row;
		row.st        = st;
		row.px        = px;
		row.has_typed = has_typed;
		row.typed_val = typed_val;
		directed_rows.push_back(row);
	endtask

	task automatic load_directed();
		settings_t s_rst;
		settings_t s_blank;
		settings_t s_plain;
		settings_t s_objoff;
		settings_t s_alpha;
		settings_t s_nowt;
		settings_t s_bright;
		settings_t s_dark;
		settings_t s_semi;
		settings_t s_nosec;
		s_rst    = '0;
		s_blank  = mk_settings(6'h3F, 8'hFF, 14'h3FFF, 5'd31, 5'd31, 5'd31, 15'h7FFF);
		s_plain  = mk_settings(6'h1F, 8'hE4, 14'h0000, 5'd0, 5'd0, 5'd0, 15'h1234);
		s_objoff = mk_settings(6'h0F, 8'h1B, 14'h0000, 5'd0, 5'd0, 5'd0, 15'h7C00);
		s_alpha  = mk_settings(6'h1F, 8'h00, 14'h3F7F, 5'd31, 5'd31, 5'd0, 15'h7FFF);
		s_nowt   = mk_settings(6'h1F, 8'h00, 14'h3F7F, 5'd0, 5'd0, 5'd0, 15'h0000);
		s_bright = mk_settings(6'h1F, 8'h00, 14'h00BF, 5'd0, 5'd0, 5'd31, 15'h0000);
		s_dark   = mk_settings(6'h1F, 8'h00, 14'h00FF, 5'd0, 5'd0, 5'd16, 15'h0000);
		s_semi   = mk_settings(6'h1F, 8'h55, 14'h3F00, 5'd8, 5'd8, 5'd0, 15'h03E0);
		s_nosec  = mk_settings(6'h1F, 8'h55, 14'h007F, 5'd8, 5'd8, 5'd0, 15'h03E0);

		// registers straight out of reset: nothing enabled, black backdrop
		add_row(s_rst, mk_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			2'd0, 1'b1, 6'h3F), 1'b1, RGBA_BLACK);
		add_row(s_rst, mk_pixel(CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd3, 1'b0, 6'h00), 1'b1, RGBA_BLACK);
		// forced blank
		add_row(s_blank, mk_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			2'd3, 1'b1, 6'h3F), 1'b1, PIXEL_WHITE);
		add_row(s_blank, mk_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			2'd0, 1'b0, 6'h00), 1'b1, PIXEL_WHITE);
		// plain priority walk, no effects
		add_row(s_plain, mk_pixel(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, CLEAR_PX,
			2'd0, 1'b0, 6'h1F), 1'b1, PIXEL_WHITE);
		add_row(s_plain, mk_pixel(CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd0, 1'b0, 6'h3F), 1'b0, '0);
		// other negative color is transparent too
		add_row(s_plain, mk_pixel(16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF, CLEAR_PX,
			2'd0, 1'b0, 6'h1F), 1'b1, RGBA_BLACK);
		add_row(s_plain, mk_pixel(16'h7C00, 16'h001F, 16'h0000, 16'h0000, 16'h03E0,
			2'd0, 1'b1, 6'h3F), 1'b0, '0);
		add_row(s_plain, mk_pixel(16'h7C00, 16'h001F, 16'h0000, 16'h0000, 16'h03E0,
			2'd3, 1'b0, 6'h3F), 1'b0, '0);
		add_row(s_plain, mk_pixel(16'h7C00, 16'h001F, 16'h0000, 16'h0000, 16'h03E0,
			2'd0, 1'b0, 6'h00), 1'b0, '0);
		add_row(s_plain, mk_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h001F,
			2'd2, 1'b0, 6'h10), 1'b0, '0);
		// sprites off, reversed background priorities
		add_row(s_objoff, mk_pixel(16'h7FFF, 16'h1234, 16'h4321, 16'h001F, 16'h7FFF,
			2'd0, 1'b0, 6'h3F), 1'b0, '0);
		add_row(s_objoff, mk_pixel(CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX, 16'h7FFF,
			2'd0, 1'b1, 6'h3F), 1'b0, '0);
		// alpha blend saturates, weights above sixteen act as sixteen
		add_row(s_alpha, mk_pixel(16'h7FFF, 16'h7FFF, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd0, 1'b0, 6'h3F), 1'b1, PIXEL_WHITE);
		add_row(s_alpha, mk_pixel(16'h1234, 16'h7FFF, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd0, 1'b0, 6'h1F), 1'b0, '0);
		add_row(s_alpha, mk_pixel(16'h0421, CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd1, 1'b0, 6'h3F), 1'b0, '0);
		add_row(s_nowt, mk_pixel(16'h7FFF, 16'h7FFF, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd0, 1'b0, 6'h3F), 1'b1, RGBA_BLACK);
		// brighten and darken at full strength
		add_row(s_bright, mk_pixel(16'h0000, CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd0, 1'b0, 6'h3F), 1'b1, PIXEL_WHITE);
		add_row(s_bright, mk_pixel(16'h1234, CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd0, 1'b0, 6'h1F), 1'b0, '0);
		add_row(s_dark, mk_pixel(16'h7FFF, CLEAR_PX, CLEAR_PX, CLEAR_PX, CLEAR_PX,
			2'd0, 1'b0, 6'h3F), 1'b1, RGBA_BLACK);
		// semi-transparent sprite overrides the mode when the layer below is a target
		add_row(s_semi, mk_pixel(16'h03E0, CLEAR_PX, CLEAR_PX, CLEAR_PX, 16'h7C1F,
			2'd0, 1'b1, 6'h3F), 1'b0, '0);
		add_row(s_semi, mk_pixel(16'h03E0, CLEAR_PX, CLEAR_PX, CLEAR_PX, 16'h7C1F,
			2'd0, 1'b0, 6'h3F), 1'b0, '0);
		add_row(s_semi, mk_pixel(16'h03E0, CLEAR_PX, CLEAR_PX, CLEAR_PX, 16'h7C1F,
			2'd0, 1'b1, 6'h1F), 1'b0, '0);
		add_row(s_nosec, mk_pixel(16'h03E0, CLEAR_PX, CLEAR_PX, CLEAR_PX, 16'h7C1F,
			2'd0, 1'b1, 6'h3F), 1'b0, '0);
	endtask

	task automatic log_mismatch(input string msg);
		fail_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------------
	// stream and register drivers
	// ------------------------------------------------------------------------
	task automatic offer_pixel(input pixel_req_t px, input logic has_typed,
			input logic [31:0] typed_val);
		typed_rgba_q.push_back({has_typed, typed_val});
		while (!steady_flow && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (rgba_due_q.size() != 0 || typed_rgba_q.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic apply_settings(input settings_t st);
		wait_drained();
		write_reg(CFG_DISPLAY_ENABLES, CFG_DAT_W'(st.enables));
		write_reg(CFG_BG_PRIORITIES, CFG_DAT_W'(st.prios));
		write_reg(CFG_BLEND_CONTROL, CFG_DAT_W'(st.blend));
		write_reg(CFG_ALPHA_FIRST, CFG_DAT_W'(st.wa));
		write_reg(CFG_ALPHA_SECOND, CFG_DAT_W'(st.wb));
		write_reg(CFG_BRIGHTNESS, CFG_DAT_W'(st.wy));
		write_reg(CFG_BACKDROP, st.backdrop);
		cfg_valid <= 1'b0;
		drv_regs = st;
		settings_count++;
	endtask

	// ------------------------------------------------------------------------
	// port monitor: shadow registers, predict on input, score on output
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		logic [32:0] typed;
		logic [31:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DISPLAY_ENABLES: live_regs.enables  = cfg_data[5:0];
					CFG_BG_PRIORITIES:   live_regs.prios    = cfg_data[7:0];
					CFG_BLEND_CONTROL:   live_regs.blend    = cfg_data[13:0];
					CFG_ALPHA_FIRST:     live_regs.wa       = cfg_data[4:0];
					CFG_ALPHA_SECOND:    live_regs.wb       = cfg_data[4:0];
					CFG_BRIGHTNESS:      live_regs.wy       = cfg_data[4:0];
					CFG_BACKDROP:        live_regs.backdrop = cfg_data[14:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pixels_in++;
				typed = (typed_rgba_q.size() != 0) ? typed_rgba_q.pop_front() : '0;
				if (typed[32]) begin
					typed_count++;
					rgba_due_q.push_back(typed[31:0]);
				end else
					rgba_due_q.push_back(composite_pixel(live_regs, s_axis_tdata));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				pixels_out++;
				if (rgba_due_q.size() == 0)
					log_mismatch($sformatf("pixel_rgba %h with no pixel pending",
						m_axis_tdata));
				else begin
					want = rgba_due_q.pop_front();
					if (m_axis_tdata !== want)
						log_mismatch($sformatf("pixel %0d pixel_rgba got %h want %h",
							pixels_out, m_axis_tdata, want));
				end
			end
		end
	end

	// output side pacing, with two long hold-offs that back the pipe up
	initial begin : sink_pacing
		int next_hold;
		int stall_cycles;
		next_hold = 500;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pixels_out >= next_hold) begin
				m_axis_tready <= 1'b0;
				for (stall_cycles = 0; stall_cycles < 120; stall_cycles++)
					@(posedge clk);
				next_hold += 1100;
			end
			m_axis_tready <= steady_flow || ($urandom_range(99) >= 22);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		settings_t st;
		int        ph;
		int        k;
		int        w;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_DISPLAY_ENABLES;
		cfg_data      <= '0;
		load_directed();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].st != drv_regs)
				apply_settings(directed_rows[i].st);
			offer_pixel(directed_rows[i].px, directed_rows[i].has_typed,
				directed_rows[i].typed_val);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: st = mk_settings(6'h1F, 8'hFF, 14'h3FFF, 5'd31, 5'd31, 5'd31, 15'h7FFF);
				1: st = mk_settings(6'h3F, 8'h00, 14'h0000, 5'd0, 5'd0, 5'd0, 15'h0000);
				2: st = mk_settings(6'h1F, 8'h00, 14'h0000, 5'd0, 5'd0, 5'd0, 15'h0000);
				3: st = mk_settings(6'h1F, 8'h1B, 14'h3F7F, 5'd16, 5'd16, 5'd16, 15'h7FFF);
				default: st = rand_settings();
			endcase
			apply_settings(st);
			steady_flow = (ph == 7 || ph == 8);
			for (k = 0; k < PHASE_PIXELS; k++) begin
				// let the pipe run dry once mid-phase
				if (ph == 5 && k == PHASE_PIXELS / 2)
					wait_drained();
				offer_pixel(rand_pixel(), 1'b0, '0);
			end
		end
		steady_flow = 1'b0;
		s_axis_tvalid <= 1'b0;

		for (w = 0; w < 5000 && rgba_due_q.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (rgba_due_q.size() != 0)
			log_mismatch($sformatf("%0d pixels never came out", rgba_due_q.size()));

		$display("ran %0d pixels through %0d register settings, %0d with hand-typed results",
			pixels_in, settings_count, typed_count);
		$display("scored %0d output pixels, %0d mismatches", pixels_out, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
